FILE: rtl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared constants, codes and controller/datapath handshake types for the
// flash page assembler.
// ----------------------------------------------------------------------------
package fpa_pkg;

	localparam int PAGE_BYTES = 256;
	localparam int BEAT_BYTES = 8;
	localparam int NUM_BEATS  = PAGE_BYTES / BEAT_BYTES;
	localparam int BEAT_W     = BEAT_BYTES * 8;
	localparam int PAGE_BITS  = $clog2(PAGE_BYTES);
	localparam int BEAT_BITS  = $clog2(BEAT_BYTES);
	localparam int IDX_W      = (NUM_BEATS > 1) ? $clog2(NUM_BEATS) : 1;

	localparam int ADDR_W      = 32;
	localparam int CAP_W       = 33;
	localparam int CNT_W       = 32;
	localparam int WORD_W      = 64;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 200;
	localparam int TUSER_W     = 8;

	localparam logic [7:0]       ERASED        = 8'hFF;
	localparam logic [CAP_W-1:0] CAPACITY_RST  = 33'd1048576;

	typedef logic [2:0] opcode_t;
	localparam opcode_t OP_DATA  = 3'd0;
	localparam opcode_t OP_END   = 3'd1;
	localparam opcode_t OP_FLUSH = 3'd2;
	localparam opcode_t OP_BAD   = 3'd3;
	localparam opcode_t OP_BEGIN = 3'd4;

	typedef logic [2:0] status_t;
	localparam status_t ST_OK          = 3'd0;
	localparam status_t ST_COMPLETE    = 3'd1;
	localparam status_t ST_NOT_STARTED = 3'd2;
	localparam status_t ST_BAD_RECORD  = 3'd3;
	localparam status_t ST_BELOW_BASE  = 3'd4;
	localparam status_t ST_TOO_LARGE   = 3'd5;
	localparam status_t ST_ABORTED     = 3'd6;

	localparam logic CFG_BASE     = 1'b0;
	localparam logic CFG_CAPACITY = 1'b1;

	typedef struct packed {
		logic    capture;
		logic    check;
		logic    range;
		logic    start;
		logic    set_sticky;
		status_t sticky_code;
		logic    count_byte;
		logic    emit_start;
		logic    beat_next;
		logic    clear_dirty;
		logic    sel_byte;
		logic    open_page;
		logic    write_byte;
		logic    load_beat;
		logic    load_close;
		status_t close_status;
	} cmd_t;

	typedef struct packed {
		opcode_t op;
		logic    started;
		logic    aborted;
		logic    dirty;
		logic    below;
		logic    too_large;
		logic    page_change;
		logic    beat_last;
		logic    slot_free;
	} sts_t;

endpackage

FILE: rtl/flash_page_assembler_core.sv
// ----------------------------------------------------------------------------
// flash_page_assembler_core
// Collects addressed image bytes into an erased page buffer and sends each
// finished page as a run of beats, followed by one closing status result.
//
//   channel  dir  transfer when          contents
//   s_axis   in   tvalid & tready        opcode, byte address, byte value
//   m_axis   out  tvalid & tready        status, page beat, counters, tlast
//   cfg      in   cfg_valid & cfg_ready  register index, write data
//
// Each command is captured, checked against base and capacity, and evaluated;
// a data byte adds a page RAM read and a write, and a page is sent as 32
// beats, each a registered page RAM read and then an output register load.
// Reset clears the control state; page buffer contents are invalidated by
// per-beat valid bits, so no clearing pass is needed.
// A stalled m_axis holds the sequencer only when it has a result to send;
// s_axis is taken again as soon as the closing result is registered.
// ----------------------------------------------------------------------------
module flash_page_assembler_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// byte_address [31:0], byte_value [39:32]
	input  logic [fpa_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// opcode [2:0]
	input  logic [fpa_pkg::TUSER_W-1:0]     s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// emitted_page_offset [31:0], page_word [95:32], image_extent [128:96],
	// bytes_placed [160:129], pages_emitted [192:161]
	output logic [fpa_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	// status [2:0], page_beat [3]
	output logic [fpa_pkg::TUSER_W-1:0]     m_axis_tuser,
	output logic                            m_axis_tlast,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic                            cfg_index,
	input  logic [fpa_pkg::CAP_W-1:0]       cfg_data
);

	fpa_pkg::cmd_t cmd;
	fpa_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	fpa_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	fpa_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_tdata  (s_axis_tdata),
		.in_tuser  (s_axis_tuser),
		.cmd       (cmd),
		.sts       (sts),
		.out_tvalid(m_axis_tvalid),
		.out_tready(m_axis_tready),
		.out_tdata (m_axis_tdata),
		.out_tuser (m_axis_tuser),
		.out_tlast (m_axis_tlast)
	);

endmodule

FILE: rtl/fpa_ram.sv
// ----------------------------------------------------------------------------
// fpa_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module fpa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/fpa_datapath.sv
// ----------------------------------------------------------------------------
// fpa_datapath
// Configuration registers, range checks, page buffer with per-beat valid
// bits, progress counters and the output register.
// ----------------------------------------------------------------------------
module fpa_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	input  logic                               cfg_index,
	input  logic [fpa_pkg::CAP_W-1:0]          cfg_data,
	input  logic [fpa_pkg::IN_TDATA_W-1:0]     in_tdata,
	input  logic [fpa_pkg::TUSER_W-1:0]        in_tuser,
	input  fpa_pkg::cmd_t                      cmd,
	output fpa_pkg::sts_t                      sts,
	output logic                               out_tvalid,
	input  logic                               out_tready,
	output logic [fpa_pkg::OUT_TDATA_W-1:0]    out_tdata,
	output logic [fpa_pkg::TUSER_W-1:0]        out_tuser,
	output logic                               out_tlast
);

	localparam int PB = fpa_pkg::PAGE_BITS;
	localparam int BW = fpa_pkg::BEAT_W;
	localparam int IW = fpa_pkg::IDX_W;

	logic [fpa_pkg::ADDR_W-1:0] base_q;
	logic [fpa_pkg::CAP_W-1:0]  cap_q;

	fpa_pkg::opcode_t           op_q;
	logic [fpa_pkg::ADDR_W-1:0] addr_q;
	logic [7:0]                 val_q;
	logic                       below_q;
	logic [fpa_pkg::ADDR_W-1:0] offset_q;
	logic                       too_large_q;
	logic [fpa_pkg::CAP_W-1:0]  ext_cand_q;
	logic                       pchange_q;

	logic                       started_q;
	fpa_pkg::status_t           sticky_q;
	logic                       dirty_q;
	logic [fpa_pkg::ADDR_W-1:0] cur_page_q;
	logic [fpa_pkg::CAP_W-1:0]  ext_q;
	logic [fpa_pkg::CNT_W-1:0]  bytes_q;
	logic [fpa_pkg::CNT_W-1:0]  pages_q;
	logic [IW-1:0]              beat_q;
	logic [fpa_pkg::NUM_BEATS-1:0] valid_q;

	logic                       out_valid_q;
	fpa_pkg::status_t           out_status_q;
	logic                       out_beat_q;
	logic [fpa_pkg::ADDR_W-1:0] out_ofs_q;
	logic [BW-1:0]              out_word_q;
	logic [fpa_pkg::CAP_W-1:0]  out_ext_q;
	logic [fpa_pkg::CNT_W-1:0]  out_bytes_q;
	logic [fpa_pkg::CNT_W-1:0]  out_pages_q;
	logic                       out_last_q;

	logic [fpa_pkg::CAP_W-1:0]  diff;
	logic [fpa_pkg::ADDR_W-1:0] pofs;
	logic [PB-1:0]              pidx;
	logic [IW-1:0]              byte_beat;
	logic [PB+2:0]              lane_sh;
	logic [IW-1:0]              raddr;
	logic [BW-1:0]              rdata;
	logic [BW-1:0]              old_word;
	logic [BW-1:0]              merged;
	logic [BW-1:0]              beat_word;
	logic                       slot_free;

	assign diff      = {1'b0, addr_q} - {1'b0, base_q};
	assign pofs      = {offset_q[fpa_pkg::ADDR_W-1:PB], {PB{1'b0}}};
	assign pidx      = offset_q[PB-1:0];
	assign byte_beat = IW'(pidx >> fpa_pkg::BEAT_BITS);
	assign lane_sh   = {pidx & PB'(fpa_pkg::BEAT_BYTES - 1), 3'b000};
	assign raddr     = cmd.sel_byte ? byte_beat : beat_q;
	assign old_word  = valid_q[byte_beat] ? rdata : {fpa_pkg::BEAT_BYTES{fpa_pkg::ERASED}};
	assign merged    = (old_word & ~(BW'(8'hFF) << lane_sh)) | (BW'(val_q) << lane_sh);
	assign beat_word = valid_q[beat_q] ? rdata : {fpa_pkg::BEAT_BYTES{fpa_pkg::ERASED}};
	assign slot_free = !out_valid_q || out_tready;

	fpa_ram #(
		.WIDTH(BW),
		.DEPTH(fpa_pkg::NUM_BEATS)
	) u_page_ram (
		.clk  (clk),
		.we   (cmd.write_byte),
		.waddr(byte_beat),
		.wdata(merged),
		.raddr(raddr),
		.rdata(rdata)
	);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			cap_q  <= fpa_pkg::CAPACITY_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				fpa_pkg::CFG_BASE:     base_q <= cfg_data[fpa_pkg::ADDR_W-1:0];
				fpa_pkg::CFG_CAPACITY: cap_q  <= cfg_data;
				default:               base_q <= base_q;
			endcase
		end
	end

	// item capture and range checks
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= in_tuser[2:0];
			addr_q <= in_tdata[fpa_pkg::ADDR_W-1:0];
			val_q  <= in_tdata[fpa_pkg::ADDR_W+7:fpa_pkg::ADDR_W];
		end
		if (cmd.check) begin
			below_q  <= diff[fpa_pkg::ADDR_W];
			offset_q <= diff[fpa_pkg::ADDR_W-1:0];
		end
		if (cmd.range) begin
			too_large_q <= {1'b0, offset_q} >= cap_q;
			ext_cand_q  <= {1'b0, offset_q} + 33'd1;
			pchange_q   <= pofs != cur_page_q;
		end
	end

	// image state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q  <= 1'b0;
			sticky_q   <= fpa_pkg::ST_OK;
			dirty_q    <= 1'b0;
			cur_page_q <= '0;
			ext_q      <= '0;
			bytes_q    <= '0;
			pages_q    <= '0;
			beat_q     <= '0;
			valid_q    <= '0;
		end else if (cmd.start) begin
			started_q  <= 1'b1;
			sticky_q   <= fpa_pkg::ST_OK;
			dirty_q    <= 1'b0;
			cur_page_q <= '0;
			ext_q      <= '0;
			bytes_q    <= '0;
			pages_q    <= '0;
			valid_q    <= '0;
		end else begin
			if (cmd.set_sticky) begin
				sticky_q <= cmd.sticky_code;
			end
			if (cmd.count_byte) begin
				bytes_q <= bytes_q + 32'd1;
				if (ext_cand_q > ext_q) begin
					ext_q <= ext_cand_q;
				end
			end
			if (cmd.emit_start) begin
				pages_q <= pages_q + 32'd1;
				beat_q  <= '0;
			end
			if (cmd.beat_next) begin
				beat_q <= beat_q + IW'(1);
			end
			if (cmd.clear_dirty) begin
				dirty_q <= 1'b0;
			end
			if (cmd.open_page) begin
				cur_page_q <= pofs;
				valid_q    <= '0;
			end
			if (cmd.write_byte) begin
				valid_q[byte_beat] <= 1'b1;
				dirty_q            <= 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_beat || cmd.load_close) begin
			out_valid_q <= 1'b1;
		end else if (out_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_beat || cmd.load_close) begin
			out_ext_q   <= ext_q;
			out_bytes_q <= bytes_q;
			out_pages_q <= pages_q;
		end
		if (cmd.load_beat) begin
			out_status_q <= fpa_pkg::ST_OK;
			out_beat_q   <= 1'b1;
			out_ofs_q    <= cur_page_q;
			out_word_q   <= beat_word;
			out_last_q   <= 1'b0;
		end else if (cmd.load_close) begin
			out_status_q <= cmd.close_status;
			out_beat_q   <= 1'b0;
			out_ofs_q    <= '0;
			out_word_q   <= '0;
			out_last_q   <= 1'b1;
		end
	end

	assign out_tvalid = out_valid_q;
	assign out_tlast  = out_last_q;
	assign out_tuser  = {4'b0000, out_beat_q, out_status_q};
	assign out_tdata  = {7'b0, out_pages_q, out_bytes_q, out_ext_q,
		fpa_pkg::WORD_W'(out_word_q), out_ofs_q};

	assign sts.op          = op_q;
	assign sts.started     = started_q;
	assign sts.aborted     = sticky_q != fpa_pkg::ST_OK;
	assign sts.dirty       = dirty_q;
	assign sts.below       = below_q;
	assign sts.too_large   = too_large_q;
	assign sts.page_change = pchange_q;
	assign sts.beat_last   = beat_q == IW'(fpa_pkg::NUM_BEATS - 1);
	assign sts.slot_free   = slot_free;

endmodule

FILE: rtl/fpa_ctrl.sv
// ----------------------------------------------------------------------------
// fpa_ctrl
// Sequencer: decodes each command, steps the page emission and the
// read-modify-write of a placed byte, and issues the closing result.
// ----------------------------------------------------------------------------
module fpa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  fpa_pkg::sts_t sts,
	output fpa_pkg::cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_RANGE,
		S_EVAL,
		S_READ,
		S_BEAT,
		S_PLACE,
		S_WRITE,
		S_CLOSE
	} state_t;

	state_t           state_q;
	state_t           state_d;
	fpa_pkg::status_t status_q;
	fpa_pkg::status_t status_d;

	always_comb begin
		cmd              = '0;
		cmd.close_status = status_q;
		state_d          = state_q;
		status_d         = status_q;
		in_ready         = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
				if (in_valid) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				state_d   = S_RANGE;
			end
			S_RANGE: begin
				cmd.range = 1'b1;
				state_d   = S_EVAL;
			end
			S_EVAL: begin
				state_d  = S_CLOSE;
				status_d = fpa_pkg::ST_OK;
				if (sts.op == fpa_pkg::OP_BEGIN) begin
					cmd.start = 1'b1;
				end else if (!(sts.op inside {[fpa_pkg::OP_DATA:fpa_pkg::OP_BAD]})) begin
					status_d = fpa_pkg::ST_OK;
				end else if (!sts.started) begin
					status_d = fpa_pkg::ST_NOT_STARTED;
				end else if (sts.aborted) begin
					status_d = fpa_pkg::ST_ABORTED;
				end else begin
					case (sts.op)
						fpa_pkg::OP_DATA: begin
							if (sts.below) begin
								cmd.set_sticky  = 1'b1;
								cmd.sticky_code = fpa_pkg::ST_BELOW_BASE;
								status_d        = fpa_pkg::ST_BELOW_BASE;
							end else if (sts.too_large) begin
								cmd.set_sticky  = 1'b1;
								cmd.sticky_code = fpa_pkg::ST_TOO_LARGE;
								status_d        = fpa_pkg::ST_TOO_LARGE;
							end else begin
								cmd.count_byte = 1'b1;
								if (sts.dirty && sts.page_change) begin
									cmd.emit_start = 1'b1;
									state_d        = S_READ;
								end else begin
									state_d = S_PLACE;
								end
							end
						end
						fpa_pkg::OP_END, fpa_pkg::OP_FLUSH: begin
							status_d = (sts.op == fpa_pkg::OP_END) ?
								fpa_pkg::ST_COMPLETE : fpa_pkg::ST_OK;
							if (sts.dirty) begin
								cmd.emit_start = 1'b1;
								state_d        = S_READ;
							end
						end
						default: begin
							cmd.set_sticky  = 1'b1;
							cmd.sticky_code = fpa_pkg::ST_BAD_RECORD;
							status_d        = fpa_pkg::ST_BAD_RECORD;
						end
					endcase
				end
			end
			S_READ: begin
				state_d = S_BEAT;
			end
			S_BEAT: begin
				if (sts.slot_free) begin
					cmd.load_beat = 1'b1;
					if (sts.beat_last) begin
						cmd.clear_dirty = 1'b1;
						state_d = (sts.op == fpa_pkg::OP_DATA) ? S_PLACE : S_CLOSE;
					end else begin
						cmd.beat_next = 1'b1;
						state_d       = S_READ;
					end
				end
			end
			S_PLACE: begin
				cmd.sel_byte  = 1'b1;
				cmd.open_page = !sts.dirty;
				state_d       = S_WRITE;
			end
			S_WRITE: begin
				cmd.sel_byte   = 1'b1;
				cmd.write_byte = 1'b1;
				state_d        = S_CLOSE;
			end
			S_CLOSE: begin
				if (sts.slot_free) begin
					cmd.load_close = 1'b1;
					state_d        = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			status_q <= fpa_pkg::ST_OK;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
		end
	end

endmodule

FILE: dv/flash_page_assembler_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flash_page_assembler_core_tb
// Drives command transfers into the page assembler and keeps its own model of
// the erased page buffer, the range checks, the sticky error and the counters.
// Every result transfer is compared field by field against the oldest
// predicted one. Directed checks cover commands before begin, page change,
// flush, end of image, errors and the region extremes. Random phases follow
// with changing base and capacity and random idling on both streams.
// ----------------------------------------------------------------------------
module flash_page_assembler_core_tb;
	import fpa_pkg::*;

	localparam int    HOLD_MAX    = 17;
	localparam int    SETTLE_CYC  = 12;
	localparam longint TIMEOUT_NS = 40_000_000;

	typedef struct {
		status_t            status;
		logic               beat;
		logic [ADDR_W-1:0]  page_ofs;
		logic [WORD_W-1:0]  word;
		logic [CAP_W-1:0]   extent;
		logic [CNT_W-1:0]   bytes;
		logic [CNT_W-1:0]   pages;
		logic               last;
	} page_result_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic [TUSER_W-1:0]     s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [TUSER_W-1:0]     m_axis_tuser;
	logic                   m_axis_tlast;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic                   cfg_index;
	logic [CAP_W-1:0]       cfg_data;

	// model state
	logic [7:0]        page_mem [PAGE_BYTES];
	logic [ADDR_W-1:0] open_page_ofs;
	logic              page_held;
	logic              started;
	status_t           sticky_code;
	logic [CAP_W-1:0]  extent_reg;
	logic [CNT_W-1:0]  bytes_reg;
	logic [CNT_W-1:0]  pages_reg;
	logic [ADDR_W-1:0] base_reg;
	logic [CAP_W-1:0]  capacity_reg;

	page_result_t page_beats [$];
	page_result_t results_due [$];

	int unsigned fail_count;
	int unsigned items_sent;
	logic        tx_idle_en;
	logic        rx_stall_en;

	flash_page_assembler_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic void erase_page(logic [ADDR_W-1:0] page_ofs);
		int i;
		for (i = 0; i < PAGE_BYTES; i++) begin
			page_mem[i] = ERASED;
		end
		open_page_ofs = page_ofs;
		page_held = 1'b0;
	endfunction

	function automatic void emit_page();
		page_result_t r;
		int b;
		int i;
		if (!page_held) begin
			return;
		end
		for (b = 0; b < NUM_BEATS; b++) begin
			r = '{default: '0};
			r.status = ST_OK;
			r.beat = 1'b1;
			r.page_ofs = open_page_ofs;
			for (i = 0; i < BEAT_BYTES; i++) begin
				r.word[8*i +: 8] = page_mem[b*BEAT_BYTES + i];
			end
			page_beats.push_back(r);
		end
		pages_reg++;
		page_held = 1'b0;
	endfunction

	task automatic apply_command(opcode_t op, logic [ADDR_W-1:0] addr, logic [7:0] value);
		status_t st;
		logic [ADDR_W-1:0] offset;
		logic [ADDR_W-1:0] page_ofs;
		page_result_t r;
		int k;
		st = ST_OK;
		page_beats.delete();
		if (op == OP_BEGIN) begin
			erase_page('0);
			started = 1'b1;
			sticky_code = ST_OK;
			extent_reg = '0;
			bytes_reg = '0;
			pages_reg = '0;
		end else if (op == OP_DATA || op == OP_END || op == OP_FLUSH || op == OP_BAD) begin
			if (!started) begin
				st = ST_NOT_STARTED;
			end else if (sticky_code != ST_OK) begin
				st = ST_ABORTED;
			end else begin
				case (op)
					OP_DATA: begin
						if (addr < base_reg) begin
							st = ST_BELOW_BASE;
						end else begin
							offset = addr - base_reg;
							if ({1'b0, offset} >= capacity_reg) begin
								st = ST_TOO_LARGE;
							end else begin
								page_ofs = {offset[ADDR_W-1:PAGE_BITS], {PAGE_BITS{1'b0}}};
								if (page_held && page_ofs != open_page_ofs) begin
									emit_page();
								end
								if (!page_held) begin
									erase_page(page_ofs);
								end
								page_mem[offset[PAGE_BITS-1:0]] = value;
								page_held = 1'b1;
								bytes_reg++;
								if ({1'b0, offset} + 33'd1 > extent_reg) begin
									extent_reg = {1'b0, offset} + 33'd1;
								end
							end
						end
						if (st != ST_OK) begin
							sticky_code = st;
						end
					end
					OP_END: begin
						emit_page();
						st = ST_COMPLETE;
					end
					OP_FLUSH: begin
						emit_page();
					end
					default: begin
						sticky_code = ST_BAD_RECORD;
						st = ST_BAD_RECORD;
					end
				endcase
			end
		end
		r = '{default: '0};
		r.status = st;
		page_beats.push_back(r);
		for (k = 0; k < page_beats.size(); k++) begin
			r = page_beats[k];
			r.extent = extent_reg;
			r.bytes = bytes_reg;
			r.pages = pages_reg;
			r.last = (k == page_beats.size() - 1);
			results_due.push_back(r);
		end
	endtask

	task automatic send_command(opcode_t op, logic [ADDR_W-1:0] addr, logic [7:0] value);
		int unsigned gap;
		gap = tx_idle_en ? $urandom_range(0, HOLD_MAX) : 0;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {value, addr};
		s_axis_tuser <= {{(TUSER_W-3){1'b0}}, op};
		do @(posedge clk); while (!s_axis_tready);
		apply_command(op, addr, value);
		items_sent++;
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (results_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [CAP_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_BASE) begin
			base_reg = value[ADDR_W-1:0];
		end else begin
			capacity_reg = value;
		end
		@(posedge clk);
	endtask

	function automatic void compare_field(string name, logic [WORD_W-1:0] want,
			logic [WORD_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endfunction

	// result checker
	always @(posedge clk) begin
		page_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (results_due.size() == 0) begin
				$error("result transfer with nothing pending");
				fail_count++;
			end else begin
				want = results_due.pop_front();
				compare_field("status", WORD_W'(want.status), WORD_W'(m_axis_tuser[2:0]));
				compare_field("page_beat", WORD_W'(want.beat), WORD_W'(m_axis_tuser[3]));
				compare_field("emitted_page_offset", WORD_W'(want.page_ofs),
					WORD_W'(m_axis_tdata[31:0]));
				compare_field("page_word", want.word, m_axis_tdata[95:32]);
				compare_field("image_extent", WORD_W'(want.extent),
					WORD_W'(m_axis_tdata[128:96]));
				compare_field("bytes_placed", WORD_W'(want.bytes),
					WORD_W'(m_axis_tdata[160:129]));
				compare_field("pages_emitted", WORD_W'(want.pages),
					WORD_W'(m_axis_tdata[192:161]));
				compare_field("last", WORD_W'(want.last), WORD_W'(m_axis_tlast));
			end
		end
	end

	// result side ready
	initial begin
		int unsigned hold;
		m_axis_tready = 1'b0;
		@(posedge clk);
		forever begin
			hold = rx_stall_en ? $urandom_range(0, HOLD_MAX) : 0;
			if (hold != 0) begin
				m_axis_tready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
		end
	end

	task automatic test_before_begin();
		send_command(OP_DATA, $urandom, 8'($urandom));
		send_command(OP_END, '0, '0);
		send_command(OP_FLUSH, '0, '0);
		send_command(OP_BAD, '0, '0);
		send_command(opcode_t'(3'd7), '1, '1);
	endtask

	task automatic test_page_basics();
		send_command(OP_BEGIN, '0, '0);
		send_command(OP_DATA, 32'h0000_0000, 8'h00);
		send_command(OP_DATA, 32'h0000_00FF, 8'hFF);
		// page change sends the first page
		send_command(OP_DATA, 32'h0000_0100, 8'h5A);
		send_command(OP_FLUSH, '0, '0);
		send_command(OP_FLUSH, '0, '0);
		send_command(opcode_t'(3'd5), $urandom, 8'($urandom));
		send_command(OP_END, '0, '0);
		// data after end of image
		send_command(OP_DATA, 32'h0000_0205, 8'hA5);
	endtask

	task automatic test_errors();
		tx_idle_en = 1'b1;
		rx_stall_en = 1'b1;
		send_command(OP_BAD, '0, '0);
		send_command(OP_DATA, 32'h0000_0010, 8'h33);
		send_command(OP_BEGIN, '0, '0);
	endtask

	task automatic test_region_edges();
		drain_results();
		write_reg(CFG_BASE, 33'h0_0000_1000);
		write_reg(CFG_CAPACITY, 33'h0_0000_2000);
		send_command(OP_BEGIN, '0, '0);
		send_command(OP_DATA, 32'h0000_0FFF, 8'h11);
		send_command(OP_BEGIN, '0, '0);
		send_command(OP_DATA, 32'h0000_2FFF, 8'h22);
		send_command(OP_DATA, 32'h0000_3000, 8'h33);
		drain_results();
		write_reg(CFG_BASE, 33'h1_FFFF_FFFF);
		write_reg(CFG_CAPACITY, 33'd1);
		send_command(OP_BEGIN, '0, '0);
		send_command(OP_DATA, 32'hFFFF_FFFF, 8'h81);
		send_command(OP_FLUSH, '0, '0);
		drain_results();
		// zero capacity
		write_reg(CFG_CAPACITY, 33'd0);
		send_command(OP_BEGIN, '0, '0);
		send_command(OP_DATA, 32'hFFFF_FFFF, 8'h7E);
		drain_results();
		write_reg(CFG_BASE, 33'd0);
		write_reg(CFG_CAPACITY, 33'h1_0000_0000);
		send_command(OP_BEGIN, '0, '0);
		send_command(OP_DATA, 32'hFFFF_FFFF, 8'hC3);
		send_command(OP_END, '0, '0);
	endtask

	task automatic test_random_traffic(int unsigned quota);
		int unsigned goal;
		int unsigned run_len;
		int unsigned n;
		int unsigned pick;
		int unsigned win;
		int unsigned cursor;
		logic [ADDR_W-1:0] base;
		logic [CAP_W-1:0] cap;
		goal = items_sent + quota;
		while (items_sent < goal) begin
			drain_results();
			tx_idle_en = ($urandom_range(0, 2) != 0);
			rx_stall_en = ($urandom_range(0, 2) != 0);
			case ($urandom_range(0, 4))
				0: begin
					base = '0;
					cap = 33'h1_0000_0000;
				end
				1: begin
					base = $urandom;
					cap = 33'($urandom_range(1, 8192));
				end
				2: begin
					base = $urandom;
					cap = {1'($urandom_range(0, 1)), 32'($urandom)};
				end
				3: begin
					base = $urandom_range(0, 32'hFFFF);
					cap = CAPACITY_RST;
				end
				default: begin
					base = 32'hFFFF_F000 | 32'($urandom_range(0, 32'hFFF));
					cap = 33'd4096;
				end
			endcase
			write_reg(CFG_BASE, {1'($urandom_range(0, 1)), base});
			write_reg(CFG_CAPACITY, cap);
			if (cap == 0) begin
				win = 1;
			end else if (cap > 33'd2048) begin
				win = 2048;
			end else begin
				win = int'(cap);
			end
			cursor = $urandom_range(0, win - 1);
			send_command(OP_BEGIN, $urandom, 8'($urandom));
			run_len = $urandom_range(20, 70);
			for (n = 0; n < run_len && items_sent < goal; n++) begin
				pick = $urandom_range(0, 99);
				if (sticky_code != ST_OK && pick < 50) begin
					send_command(OP_BEGIN, $urandom, 8'($urandom));
				end else if (pick < 72) begin
					if ($urandom_range(0, 9) == 0) begin
						cursor = $urandom_range(0, win - 1);
					end else begin
						cursor = (cursor + 1) % win;
					end
					send_command(OP_DATA, base + cursor, 8'($urandom));
				end else if (pick < 79) begin
					send_command(OP_FLUSH, $urandom, 8'($urandom));
				end else if (pick < 84) begin
					send_command(OP_END, $urandom, 8'($urandom));
				end else if (pick < 86) begin
					send_command(OP_BAD, $urandom, 8'($urandom));
				end else if (pick < 89) begin
					send_command(opcode_t'($urandom_range(5, 7)), $urandom, 8'($urandom));
				end else if (pick < 93) begin
					send_command(OP_BEGIN, $urandom, 8'($urandom));
				end else begin
					send_command(OP_DATA, $urandom, 8'($urandom));
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_BASE;
		cfg_data = '0;
		tx_idle_en = 1'b0;
		rx_stall_en = 1'b0;
		fail_count = 0;
		items_sent = 0;
		erase_page('0);
		started = 1'b0;
		sticky_code = ST_OK;
		extent_reg = '0;
		bytes_reg = '0;
		pages_reg = '0;
		base_reg = '0;
		capacity_reg = CAPACITY_RST;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_before_begin();
		test_page_basics();
		test_errors();
		test_region_edges();
		test_random_traffic(360);
		drain_results();
		if (fail_count == 0) begin
			$display("PASS flash_page_assembler_core");
		end else begin
			$display("FAIL flash_page_assembler_core");
		end
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("FAIL flash_page_assembler_core");
		$finish;
	end

endmodule

FILE: sim.f
rtl/fpa_pkg.sv
rtl/fpa_ram.sv
rtl/fpa_datapath.sv
rtl/fpa_ctrl.sv
rtl/flash_page_assembler_core.sv
dv/flash_page_assembler_core_tb.sv
